// ----- src/wtd_pkg.sv -----
// Package for the word tokenizer with frequency dictionary.
// Holds payload structs, sizing constants and the character helpers.
// No dependencies.
package wtd_pkg;

  localparam int NumEntriesDef = 256;
  localparam int MaxWordLenDef = 16;
  localparam logic [7:0]  Apostrophe = 8'h27;
  localparam logic [31:0] CountMax   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  token_id;
    logic        is_new;
    logic [31:0] word_count;
    logic        table_full;
    logic [8:0]  entries_used;
  } out_word_t;

  function automatic logic is_word_char(input logic [7:0] c);
    is_word_char = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
                   (c >= 8'h30 && c <= 8'h39) || (c == Apostrophe);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

endpackage

// ----- src/wtd_cell.sv -----
// One dictionary cell: holds one stored word and its count.
// A search token passes from cell to cell, one cell per cycle.
// Depends on wtd_pkg.
module wtd_cell
  import wtd_pkg::*;
#(
  parameter int MaxWordLen = MaxWordLenDef,
  parameter int LenW       = $clog2(MaxWordLen + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear_i,
  input  logic [MaxWordLen-1:0][7:0] word_i,
  input  logic [LenW-1:0]            len_i,
  input  logic                       tok_i,
  output logic                       tok_o,
  output logic                       hit_o,
  output logic                       free_o,
  output logic [31:0]                count_o
);

  logic                       used_r;
  logic [MaxWordLen-1:0][7:0] chars_r;
  logic [LenW-1:0]            len_r;
  logic [31:0]                count_r;
  logic                       match;
  logic                       tok_r;

  always_comb begin
    match = used_r && (len_r == len_i);
    for (int k = 0; k < MaxWordLen; k++) begin
      if (k < len_i && chars_r[k] != word_i[k]) match = 1'b0;
    end
  end

  // The token stops at the first hit or at the first free cell.
  assign hit_o   = tok_i && match;
  assign free_o  = tok_i && !used_r;
  assign count_o = hit_o ? ((count_r == CountMax) ? count_r : count_r + 32'd1) : 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n || clear_i) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_i && used_r && !match;
    end
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (free_o) begin
      used_r <= 1'b1;
    end
    if (free_o) begin
      chars_r <= word_i;
      len_r   <= len_i;
      count_r <= 32'd1;
    end else if (hit_o) begin
      count_r <= count_o;
    end
  end

  assign tok_o = tok_r;

endmodule

// ----- src/word_tokenizer_dictionary.sv -----
// Top level of the word tokenizer with frequency dictionary.
// Gathers words and searches a chain of wtd_cell instances. Depends on wtd_pkg and wtd_cell.
//
//  channel | dir | handshake         | payload
//  in      | in  | in_valid/in_stall | in_word_t
//  out     | out | out_valid/out_stall | out_word_t
//
// A byte that does not close a word starts no search.
// A closing byte starts a token down the cell chain, one cell per cycle; the
// search ends at the first hit, at the first free cell or at the chain's end.
// Reset clears the dictionary at once through the cells' used bits.
// The input stalls during a search and while a result waits for the output.
module word_tokenizer_dictionary
  import wtd_pkg::*;
#(
  parameter int NumEntries = NumEntriesDef,
  parameter int MaxWordLen = MaxWordLenDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int LenW = $clog2(MaxWordLen + 1);
  localparam int IdxW = $clog2(NumEntries);
  localparam int UsedW = $clog2(NumEntries + 1);

  logic [MaxWordLen-1:0][7:0] buf_r, buf_nxt;
  logic [LenW-1:0]            len_r, len_nxt;
  logic                       busy_r;
  logic [UsedW-1:0]           used_r;
  logic [NumEntries:0]        tok;
  logic [NumEntries-1:0]      hit, free;
  logic [NumEntries-1:0][31:0] cnt;
  logic                       done;
  logic                       found;
  logic [IdxW-1:0]            idx;
  logic [31:0]                fcnt;
  logic                       accept, wc, close;

  assign in_stall = busy_r || out_valid;
  assign accept   = in_valid && !in_stall;
  assign wc       = is_word_char(in_data.char_byte);

  always_comb begin
    buf_nxt = buf_r;
    len_nxt = len_r;
    if (wc && len_r < LenW'(MaxWordLen)) begin
      buf_nxt[len_r[$clog2(MaxWordLen)-1:0]] = to_lower(in_data.char_byte);
      len_nxt = len_r + LenW'(1);
    end
  end
  assign close = accept && (!wc || in_data.end_of_text) && len_nxt != '0;

  genvar g;
  generate
    for (g = 0; g < NumEntries; g++) begin : g_cell
      wtd_cell #(.MaxWordLen(MaxWordLen), .LenW(LenW)) u_cell (
        .clk(clk), .rst_n(rst_n), .clear_i(done), .word_i(buf_r), .len_i(len_r),
        .tok_i(tok[g]), .tok_o(tok[g+1]), .hit_o(hit[g]), .free_o(free[g]),
        .count_o(cnt[g])
      );
    end
  endgenerate

  // The token is injected by a start register.
  logic start_r;
  always_comb begin
    found = 1'b0;
    idx   = '0;
    fcnt  = 32'd1;
    for (int i = 0; i < NumEntries; i++) begin
      if (hit[i] || free[i]) begin
        found = 1'b1;
        idx   = IdxW'(i);
        fcnt  = cnt[i];
      end
    end
  end
  assign done = busy_r && (found || tok[NumEntries]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0; busy_r <= 1'b0; used_r <= '0; out_valid <= 1'b0; start_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (accept) begin
        buf_r <= buf_nxt;
        len_r <= close ? len_nxt : (in_data.end_of_text ? '0 : len_nxt);
        if (close) begin
          busy_r  <= 1'b1;
          start_r <= 1'b1;
        end
      end
      if (done) begin
        busy_r    <= 1'b0;
        len_r     <= '0;
        out_valid <= 1'b1;
        out_data.token_id   <= found ? 8'(idx) : 8'd0;
        out_data.is_new     <= found && (|free);
        out_data.word_count <= found ? fcnt : 32'd0;
        out_data.table_full <= !found;
        out_data.entries_used <= 9'((found && (|free)) ? used_r + UsedW'(1) : used_r);
        if (found && (|free)) used_r <= used_r + UsedW'(1);
      end
    end
  end

  // Token enters the first cell in the cycle after the word closes.
  assign tok[0] = start_r;

  assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit | free))
    else $error("more than one cell answered");
  assert property (@(posedge clk) disable iff (!rst_n) done |=> out_valid)
    else $error("finished search gave no result");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> in_stall)
    else $error("input taken during search");

endmodule
